>>> rtl/core/brf_pkg.sv
// Package for the byte ring FIFO with peek: item structs, request codes
// and fixed widths. No dependencies.
package brf_pkg;

  localparam int DATA_W = 8;
  localparam int CAP_W  = 9;
  localparam int CNT_W  = 7;

  // Result queue between the back end and the output port.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DATA_W-1:0] data_in;
    logic [CNT_W-1:0]  peek_count;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              ok;
    logic [CAP_W-1:0]  used;
    logic [CAP_W-1:0]  available;
    logic              last;
  } out_item_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    req_e              req;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
  } cmd_t;

endpackage

>>> rtl/core/byte_ring_fifo_with_peek.sv
// Top level of the byte ring FIFO with peek. Instantiates brf_front,
// brf_back and brf_outq; uses brf_pkg.
//
// Requests enter through a queue-style port: an item is taken when push is
// high and full is low. Results leave the same way: the oldest result sits
// on out_item while empty is low and is taken when pop is high.
// Each request gives one result, except a peek that returns bytes, which
// gives one result per byte (at most MAX_PEEK), the final one marked by last.
// The capacity register is written through cfg_valid/cfg_ready/cfg_data,
// which is always ready; write it only while no request is outstanding.
// Push, pop and clear run at one item per cycle while the result queue
// has room; a result passes the request queue, the back end's stage
// register and the result queue before it sits on out_item. A peek holds
// the back end until its last byte is issued, one store read per byte.
// The back end is limited by the single store read port and by the
// four-entry result queue: when the receiver stops popping, the result
// queue fills, the back end halts, and then the two-entry request queue
// fills and raises full.
// Reset empties both queues, zeroes the ring pointers and occupancy and
// sets the capacity to DEPTH, at most 256. The byte store is not cleared.
module byte_ring_fifo_with_peek #(
  parameter int DEPTH    = 256,
  parameter int MAX_PEEK = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  brf_pkg::in_item_t         in_item,
  output logic                      empty,
  input  logic                      pop,
  output brf_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [brf_pkg::CAP_W-1:0] cfg_data
);
  import brf_pkg::*;

  logic             cmd_valid;
  logic             cmd_take;
  cmd_t             cmd;
  logic [OQ_CW-1:0] oq_count;
  logic             oq_wr;
  out_item_t        oq_item;

  brf_front #(
    .MAX_PEEK(MAX_PEEK)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd      (cmd)
  );

  brf_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd      (cmd),
    .oq_count (oq_count),
    .oq_wr    (oq_wr),
    .oq_item  (oq_item)
  );

  brf_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr      (oq_wr),
    .wr_item (oq_item),
    .count   (oq_count),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  // The back end must never write a result into a full result queue.
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    oq_wr |-> (oq_count < OQ_CW'(OQ_DEPTH)))
    else $error("result written into a full result queue");

  // A request is only taken from the command queue when one is waiting.
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken from an empty command queue");

  // A result that returns no byte carries a zero byte.
  a_nok_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.ok) |-> (out_item.data_out == '0 && out_item.last))
    else $error("failed result carries data or is not final");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

endmodule

>>> rtl/core/brf_front.sv
// Front end: accepts input items, decodes the request and clips the peek
// count, and holds them in a two-entry command queue. Uses brf_pkg.
module brf_front #(
  parameter int MAX_PEEK = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  brf_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output brf_pkg::cmd_t     cmd
);
  import brf_pkg::*;

  cmd_t       q [2];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] count;
  logic       accept;
  cmd_t       cmd_in;

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_idx];

  always_comb begin
    cmd_in.req  = req_e'(in_item.req_type);
    cmd_in.data = in_item.data_in;
    if (int'(in_item.peek_count) > MAX_PEEK) begin
      cmd_in.count = CNT_W'(MAX_PEEK);
    end else begin
      cmd_in.count = in_item.peek_count;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_idx] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_idx <= ~wr_idx;
      end
      if (cmd_take) begin
        rd_idx <= ~rd_idx;
      end
      count <= count + 2'(accept) - 2'(cmd_take);
    end
  end

endmodule

>>> rtl/core/brf_back.sv
// Back end: ring pointers, occupancy, capacity register, byte store and
// the peek sequencer. Each issued result passes one register stage that
// lines up with the registered store read. Uses brf_pkg.
module brf_back #(
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [brf_pkg::CAP_W-1:0]  cfg_data,
  input  logic                       cmd_valid,
  output logic                       cmd_take,
  input  brf_pkg::cmd_t              cmd,
  input  logic [brf_pkg::OQ_CW-1:0]  oq_count,
  output logic                       oq_wr,
  output brf_pkg::out_item_t         oq_item
);
  import brf_pkg::*;

  localparam int PW    = $clog2(DEPTH);
  localparam int CMP_W = (PW + 1 > CAP_W) ? PW + 1 : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'((DEPTH < 256) ? DEPTH : 256);

  typedef enum logic {S_IDLE, S_PEEK} state_t;

  state_t            state, state_next;
  logic [CAP_W-1:0]  cap;
  logic [CAP_W-1:0]  cap_in;
  logic [PW-1:0]     rd_ptr, rd_ptr_next;
  logic [PW-1:0]     wr_ptr, wr_ptr_next;
  logic [CAP_W-1:0]  occ, occ_next;
  logic [PW-1:0]     pk_ptr, pk_ptr_next;
  logic [CNT_W-1:0]  pk_left, pk_left_next;
  logic [CNT_W-1:0]  pk_n;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic              mem_we;
  logic              mem_re;
  logic [PW-1:0]     rd_addr;

  logic              room;
  logic              issue;
  logic              iss_ok;
  logic              iss_last;
  logic              iss_mem;
  logic [CAP_W-1:0]  iss_avail;

  logic              s_valid;
  logic              s_mem;
  logic              s_ok;
  logic              s_last;
  logic [CAP_W-1:0]  s_used;
  logic [CAP_W-1:0]  s_avail;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CAP_W-1:0] c);
    logic [CMP_W-1:0] n;
    n = CMP_W'(p) + CMP_W'(1);
    adv = (n >= CMP_W'(c)) ? '0 : p + PW'(1);
  endfunction

  assign cfg_ready = 1'b1;

  // The capacity register holds the effective value: zero acts as one and
  // anything beyond the store acts as the store size.
  always_comb begin
    if (cfg_data == '0) begin
      cap_in = CAP_W'(1);
    end else if (int'(cfg_data) > DEPTH) begin
      cap_in = CAP_W'(DEPTH);
    end else begin
      cap_in = cfg_data;
    end
  end

  // A new result is issued only if the result queue can still take it
  // after the one already in the stage register lands there.
  assign room = ({1'b0, oq_count} + (OQ_CW + 1)'(s_valid)) < (OQ_CW + 1)'(OQ_DEPTH);

  assign pk_n = ({2'b00, cmd.count} > occ) ? occ[CNT_W-1:0] : cmd.count;

  always_comb begin
    state_next   = state;
    rd_ptr_next  = rd_ptr;
    wr_ptr_next  = wr_ptr;
    occ_next     = occ;
    pk_ptr_next  = pk_ptr;
    pk_left_next = pk_left;
    cmd_take     = 1'b0;
    issue        = 1'b0;
    iss_ok       = 1'b0;
    iss_last     = 1'b1;
    iss_mem      = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    rd_addr      = rd_ptr;
    case (state)
      S_IDLE: begin
        if (cmd_valid && room) begin
          cmd_take = 1'b1;
          case (cmd.req)
            REQ_PUSH: begin
              issue = 1'b1;
              if (occ < cap) begin
                mem_we      = 1'b1;
                wr_ptr_next = adv(wr_ptr, cap);
                occ_next    = occ + CAP_W'(1);
                iss_ok      = 1'b1;
              end
            end
            REQ_POP: begin
              issue = 1'b1;
              if (occ != '0) begin
                mem_re      = 1'b1;
                rd_ptr_next = adv(rd_ptr, cap);
                occ_next    = occ - CAP_W'(1);
                iss_ok      = 1'b1;
                iss_mem     = 1'b1;
              end
            end
            REQ_PEEK: begin
              if (pk_n == '0) begin
                issue = 1'b1;
              end else begin
                pk_ptr_next  = rd_ptr;
                pk_left_next = pk_n;
                state_next   = S_PEEK;
              end
            end
            REQ_CLEAR: begin
              issue       = 1'b1;
              rd_ptr_next = '0;
              wr_ptr_next = '0;
              occ_next    = '0;
            end
            default: begin
              issue = 1'b1;
            end
          endcase
        end
      end
      S_PEEK: begin
        if (room) begin
          issue        = 1'b1;
          iss_ok       = 1'b1;
          iss_mem      = 1'b1;
          iss_last     = (pk_left == CNT_W'(1));
          mem_re       = 1'b1;
          rd_addr      = pk_ptr;
          pk_ptr_next  = adv(pk_ptr, cap);
          pk_left_next = pk_left - CNT_W'(1);
          if (pk_left == CNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign iss_avail = (occ_next >= cap) ? '0 : cap - occ_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= cmd.data;
    end
    if (mem_re) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cap     <= CAP_RESET;
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      occ     <= '0;
      pk_left <= '0;
      s_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_ptr  <= rd_ptr_next;
      wr_ptr  <= wr_ptr_next;
      occ     <= occ_next;
      pk_left <= pk_left_next;
      s_valid <= issue;
      if (cfg_valid) begin
        cap <= cap_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    pk_ptr <= pk_ptr_next;
    if (issue) begin
      s_mem   <= iss_mem;
      s_ok    <= iss_ok;
      s_last  <= iss_last;
      s_used  <= occ_next;
      s_avail <= iss_avail;
    end
  end

  assign oq_wr = s_valid;

  always_comb begin
    oq_item.data_out  = s_mem ? mem_q : '0;
    oq_item.ok        = s_ok;
    oq_item.used      = s_used;
    oq_item.available = s_avail;
    oq_item.last      = s_last;
  end

endmodule

>>> rtl/core/brf_outq.sv
// Result queue of brf_pkg::OQ_DEPTH entries between the back end and the
// output port. Uses brf_pkg.
module brf_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr,
  input  brf_pkg::out_item_t        wr_item,
  output logic [brf_pkg::OQ_CW-1:0] count,
  output logic                      empty,
  input  logic                      pop,
  output brf_pkg::out_item_t        out_item
);
  import brf_pkg::*;

  out_item_t        q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_idx;
  logic [OQ_AW-1:0] rd_idx;
  logic             rd;

  assign empty    = (count == '0);
  assign rd       = pop && !empty;
  assign out_item = q[rd_idx];

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_idx] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_idx <= wr_idx + OQ_AW'(1);
      end
      if (rd) begin
        rd_idx <= rd_idx + OQ_AW'(1);
      end
      count <= count + OQ_CW'(wr) - OQ_CW'(rd);
    end
  end

endmodule
